[hdl/knn_pkg.sv]
// Shared types and field widths for the k-nearest-neighbour vote classifier.
package knn_pkg;

    // Fixed field widths of the stream and configuration payloads
    localparam int DIST_FIELD_W = 32;
    localparam int LABEL_W      = 8;
    localparam int VOTE_W       = 5;
    localparam int CFG_W        = 5;
    localparam int IN_DATA_W    = 40;  // distance + class_label, whole bytes
    localparam int OUT_DATA_W   = 16;  // predicted_label + vote_count, padded

    // Per-cycle command to every cell of the chain
    typedef struct packed {
        logic ins;    // insert a new point
        logic load;   // capture candidates for the vote
        logic count;  // rotate label ring and count matches
        logic scan;   // shift candidates towards cell 0
    } cell_ctrl_t;

endpackage

[hdl/knn_cell.sv]
// One cell of the sorted-neighbour chain: insertion slot plus vote counter.
module knn_cell #(
    parameter int DW = 32,
    parameter int CW = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  knn_pkg::cell_ctrl_t         ctrl,
    input  logic                        occ,
    input  logic [DW-1:0]               new_dist,
    input  logic [knn_pkg::LABEL_W-1:0] new_label,
    input  logic                        prev_gt,
    input  logic [DW-1:0]               prev_dist,
    input  logic [knn_pkg::LABEL_W-1:0] prev_label,
    input  logic [knn_pkg::LABEL_W-1:0] nxt_label,
    input  logic                        nxt_ring_occ,
    input  logic [knn_pkg::LABEL_W-1:0] nxt_cand,
    input  logic [CW-1:0]               nxt_cnt,
    input  logic                        nxt_cand_occ,
    output logic                        gt,
    output logic [DW-1:0]               kept_dist,
    output logic [knn_pkg::LABEL_W-1:0] label,
    output logic                        ring_occ,
    output logic [knn_pkg::LABEL_W-1:0] cand,
    output logic [CW-1:0]               cnt,
    output logic                        cand_occ
);
    import knn_pkg::*;

    logic [DW-1:0]      dist_reg;
    logic [LABEL_W-1:0] label_reg;
    logic               ring_occ_reg;
    logic [LABEL_W-1:0] cand_reg;
    logic [CW-1:0]      cnt_reg;
    logic               cand_occ_reg;
    logic               match;

    // New point ranks before this entry (ties keep the older entry first)
    assign gt    = !(occ && (dist_reg <= new_dist));
    assign match = cand_occ_reg && ring_occ_reg && (label_reg == cand_reg);

    // Occupancy flags for the vote phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_occ_reg <= 1'b0;
            cand_occ_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                ring_occ_reg <= occ;
                cand_occ_reg <= occ;
            end
            else if (ctrl.count)
                ring_occ_reg <= nxt_ring_occ;
            else if (ctrl.scan)
                cand_occ_reg <= nxt_cand_occ;
        end
    end

    // Entry payload: insert/shift, ring rotation, candidate shift-out
    always_ff @(posedge clk)
    begin
        if (ctrl.ins && gt)
        begin
            dist_reg  <= prev_gt ? prev_dist : new_dist;
            label_reg <= prev_gt ? prev_label : new_label;
        end
        else if (ctrl.count)
            label_reg <= nxt_label;

        if (ctrl.load)
        begin
            cand_reg <= label_reg;
            cnt_reg  <= '0;
        end
        else if (ctrl.count)
            cnt_reg <= cnt_reg + CW'(match);
        else if (ctrl.scan)
        begin
            cand_reg <= nxt_cand;
            cnt_reg  <= nxt_cnt;
        end
    end

    assign kept_dist = dist_reg;
    assign label     = label_reg;
    assign ring_occ  = ring_occ_reg;
    assign cand      = cand_reg;
    assign cnt       = cnt_reg;
    assign cand_occ  = cand_occ_reg;

endmodule

[hdl/knn_majority_vote_classifier.sv]
// Top level: chain of sorted-neighbour cells with a vote sequencer.
//
//  channel        | direction | payload (low bit first)                 | marker
//  s_axis         | in        | distance[31:0], class_label[39:32]      | tlast = last
//  m_axis         | out       | predicted_label[7:0], vote_count[12:8]  | -
//  neighbour_count| cfg write | neighbour_count[4:0] when _we high      | -
//
// Each training point is inserted with all cells comparing and shifting in parallel.
// A transaction with tlast then starts the vote (one load, a full ring rotation
// to count, a full shift-out to pick the winner, one hand-over to the output
// register); s_axis_tready is low until the vote is done.
// Reset empties the kept list and sets neighbour_count to 1.
// A result waiting on m_axis does not block new points; a further vote waits
// for the output register to free up.
module knn_majority_vote_classifier #(
    parameter int MAX_NEIGHBOURS = 16,
    parameter int DISTANCE_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [knn_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // distance, class_label
    input  logic                           s_axis_tlast,   // last
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [knn_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // predicted_label, vote_count
    input  logic                           neighbour_count_we,
    input  logic [knn_pkg::CFG_W-1:0]      neighbour_count
);
    import knn_pkg::*;

    localparam int M  = MAX_NEIGHBOURS;
    localparam int DW = (DISTANCE_BITS < DIST_FIELD_W) ? DISTANCE_BITS : DIST_FIELD_W;
    localparam int CW = $clog2(M + 1);
    localparam int KW = (CW > CFG_W) ? CW : CFG_W;
    localparam int SW = (M > 1) ? $clog2(M) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COUNT,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   k_cfg_reg;
    logic [CW-1:0]      fill_reg;
    logic [SW-1:0]      step_reg;
    logic [LABEL_W-1:0] best_lab_reg;
    logic [CW-1:0]      best_cnt_reg;
    logic               out_valid_reg;
    logic [LABEL_W-1:0] out_lab_reg;
    logic [VOTE_W-1:0]  out_cnt_reg;

    logic [KW-1:0]      k_eff;
    logic [KW-1:0]      n_kept;
    logic [KW-1:0]      fill_ins;
    logic               in_acc;
    logic               step_end;
    logic               better;
    cell_ctrl_t         ctrl;
    logic [DW-1:0]      in_dist;
    logic [LABEL_W-1:0] in_label;

    logic [M-1:0]               gt_w;
    logic [M-1:0]               occ_w;
    logic [M-1:0]               ring_occ_w;
    logic [M-1:0]               cand_occ_w;
    logic [DW-1:0]              dist_w  [M];
    logic [LABEL_W-1:0]         label_w [M];
    logic [LABEL_W-1:0]         cand_w  [M];
    logic [CW-1:0]              cnt_w   [M];

    assign in_dist  = s_axis_tdata[DW-1:0];
    assign in_label = s_axis_tdata[DIST_FIELD_W +: LABEL_W];

    // Effective K clamped to 1..M, kept count trimmed to K
    always_comb
    begin
        if (k_cfg_reg == '0)
            k_eff = KW'(1);
        else if (KW'(k_cfg_reg) > KW'(M))
            k_eff = KW'(M);
        else
            k_eff = KW'(k_cfg_reg);
        n_kept   = (KW'(fill_reg) > k_eff) ? k_eff : KW'(fill_reg);
        fill_ins = (n_kept < k_eff) ? (n_kept + KW'(1)) : k_eff;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign step_end      = (step_reg == SW'(M - 1));

    assign ctrl.ins   = in_acc;
    assign ctrl.load  = (state_reg == ST_LOAD);
    assign ctrl.count = (state_reg == ST_COUNT);
    assign ctrl.scan  = (state_reg == ST_SCAN);

    // Cell chain: prev neighbour for insertion, next neighbour for ring and scan
    for (genvar i = 0; i < M; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? 0 : i - 1;
        localparam int NXT  = (i == M - 1) ? 0 : i + 1;

        assign occ_w[i] = (KW'(i) < n_kept);

        knn_cell #(
            .DW (DW),
            .CW (CW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .occ          (occ_w[i]),
            .new_dist     (in_dist),
            .new_label    (in_label),
            .prev_gt      ((i == 0) ? 1'b0 : gt_w[PREV]),
            .prev_dist    (dist_w[PREV]),
            .prev_label   (label_w[PREV]),
            .nxt_label    (label_w[NXT]),
            .nxt_ring_occ (ring_occ_w[NXT]),
            .nxt_cand     (cand_w[NXT]),
            .nxt_cnt      (cnt_w[NXT]),
            .nxt_cand_occ ((i == M - 1) ? 1'b0 : cand_occ_w[NXT]),
            .gt           (gt_w[i]),
            .kept_dist    (dist_w[i]),
            .label        (label_w[i]),
            .ring_occ     (ring_occ_w[i]),
            .cand         (cand_w[i]),
            .cnt          (cnt_w[i]),
            .cand_occ     (cand_occ_w[i])
        );
    end

    // Candidate leaving cell 0 beats the best so far (ties to smaller label)
    assign better = cand_occ_w[0] &&
                    ((cnt_w[0] > best_cnt_reg) ||
                     ((cnt_w[0] == best_cnt_reg) && (cand_w[0] < best_lab_reg)));

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_cfg_reg <= CFG_W'(1);
        else if (neighbour_count_we)
            k_cfg_reg <= neighbour_count;
    end

    // Vote sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            step_reg      <= '0;
            best_lab_reg  <= '0;
            best_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_lab_reg   <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            // Hand-over state loads its own result, so it owns the flag then
            if (out_valid_reg && m_axis_tready && (state_reg != ST_HOLD))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        fill_reg <= CW'(fill_ins);
                        if (s_axis_tlast)
                            state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    fill_reg     <= '0;
                    step_reg     <= '0;
                    best_lab_reg <= '0;
                    best_cnt_reg <= '0;
                    state_reg    <= ST_COUNT;
                end
                ST_COUNT:
                begin
                    if (step_end)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_SCAN;
                    end
                    else
                        step_reg <= step_reg + SW'(1);
                end
                ST_SCAN:
                begin
                    if (better)
                    begin
                        best_lab_reg <= cand_w[0];
                        best_cnt_reg <= cnt_w[0];
                    end
                    if (step_end)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_HOLD;
                    end
                    else
                        step_reg <= step_reg + SW'(1);
                end
                ST_HOLD:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_lab_reg   <= best_lab_reg;
                        out_cnt_reg   <= VOTE_W'(best_cnt_reg);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - LABEL_W - VOTE_W){1'b0}}, out_cnt_reg, out_lab_reg};

    // Kept count never exceeds the chain length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        KW'(fill_reg) <= KW'(M))
        else $error("kept count exceeds chain length");

    // A final transaction always starts the vote
    a_last_starts_vote: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tlast) |=> (state_reg == ST_LOAD))
        else $error("vote not started after final transaction");

    // The list is empty while the vote counts and scans
    a_empty_in_vote: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_COUNT) || (state_reg == ST_SCAN)) |-> (fill_reg == '0))
        else $error("kept list not emptied at vote start");

    // A vote always covers at least one neighbour
    a_vote_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_cnt_reg != '0))
        else $error("result with zero vote count");

    // A new result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> $stable(out_lab_reg))
        else $error("pending result overwritten");

endmodule
